>>> sv/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// Shared types and codes for the voice slot allocator.
// ----------------------------------------------------------------------------
package vsa_pkg;

  localparam int VOICE_SLOTS_DEF = 32;
  localparam int HANDLE_BITS_DEF = 32;

  localparam logic [15:0] FULL_AUDIBILITY = 16'd32768;

  // operation codes
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_UPDATE  = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT   = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_INVALID   = 2'd3;

  // steal modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_PRIORITY = 2'd1;
  localparam logic [1:0] MODE_QUIETEST = 2'd2;
  localparam logic [1:0] MODE_OLDEST   = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  priority_req;
    logic [31:0] handle;
    logic [15:0] audibility;
  } in_item_t;

  typedef struct packed {
    logic [31:0] new_handle;
    logic [4:0]  slot;
    logic        stolen;
    logic [1:0]  status;
    logic [5:0]  active_count;
  } out_item_t;

endpackage

>>> sv/vsa_ram.sv
// ----------------------------------------------------------------------------
// vsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/voice_slot_allocator_with_stealing_unit.sv
// ----------------------------------------------------------------------------
// voice_slot_allocator_with_stealing_unit
// Voice slot pool with request, release, update and stealing of lower-priority voices.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  input     start, busy, in_item          taken when start & !busy
//  result    out_valid, out_item           one-cycle strobe, no back-pressure
//  config    cfg_valid, cfg_ready, cfg_data written when cfg_valid & cfg_ready
//
//  Each item reads the slot RAM once per slot, waits out the read latency,
//  then takes a commit step that writes the RAM; the result strobe follows
//  while the next item can be taken.
//  Busy flags live in flops and clear at reset; the RAM needs no clearing.
//  Reset is synchronous, active low. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module voice_slot_allocator_with_stealing_unit #(
  parameter int VOICE_SLOTS = vsa_pkg::VOICE_SLOTS_DEF,
  parameter int HANDLE_BITS = vsa_pkg::HANDLE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  vsa_pkg::in_item_t in_item,
  output logic              out_valid,
  output vsa_pkg::out_item_t out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data
);

  localparam int SLOT_W = $clog2(VOICE_SLOTS);
  localparam int CNT_W  = $clog2(VOICE_SLOTS + 1);
  localparam int ENT_W  = HANDLE_BITS + 8 + 16;
  localparam int CMP_W  = (HANDLE_BITS > 32) ? HANDLE_BITS : 32;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [SLOT_W:0]        iss_r, iss_nxt;
  logic                   ev_vld_r, ev_vld_nxt;
  logic [SLOT_W-1:0]      ev_idx_r, ev_idx_nxt;
  logic [VOICE_SLOTS-1:0] busy_r, busy_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [HANDLE_BITS-1:0] nh_r, nh_nxt, nh_inc;
  logic [1:0]             mode_r, mode_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // item and scan trackers (payload, no reset)
  vsa_pkg::in_item_t      item_r;
  vsa_pkg::out_item_t     res_r, res_nxt;
  logic                   free_fnd_r, free_fnd_nxt;
  logic [SLOT_W-1:0]      free_idx_r, free_idx_nxt;
  logic                   hit_fnd_r, hit_fnd_nxt;
  logic [SLOT_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic                   best_fnd_r, best_fnd_nxt;
  logic [SLOT_W-1:0]      best_idx_r, best_idx_nxt;
  logic [7:0]             best_prio_r, best_prio_nxt;
  logic [15:0]            best_aud_r, best_aud_nxt;
  logic [HANDLE_BITS-1:0] best_hdl_r, best_hdl_nxt;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]       ram_wdata;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]       ram_rdata;

  logic [HANDLE_BITS-1:0] rd_hdl;
  logic [7:0]             rd_prio;
  logic [15:0]            rd_aud;
  logic                   rd_busy;
  logic                   better;
  logic                   accept;
  logic                   scan_done;

  vsa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (VOICE_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  assign rd_hdl    = ram_rdata[ENT_W-1 -: HANDLE_BITS];
  assign rd_prio   = ram_rdata[23:16];
  assign rd_aud    = ram_rdata[15:0];
  assign rd_busy   = busy_r[ev_idx_r];
  assign ram_raddr = iss_r[SLOT_W-1:0];
  assign scan_done = (iss_r == (SLOT_W+1)'(VOICE_SLOTS));

  assign nh_inc = nh_r + HANDLE_BITS'(1);

  always_comb begin
    case (mode_r)
      vsa_pkg::MODE_PRIORITY: better = rd_prio < best_prio_r;
      vsa_pkg::MODE_QUIETEST: better = rd_aud < best_aud_r;
      default:                better = rd_hdl < best_hdl_r;
    endcase
  end

  always_comb begin
    logic             req_ok;
    logic             stole;
    logic [SLOT_W-1:0] sel;

    state_nxt     = state_r;
    iss_nxt       = iss_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    nh_nxt        = nh_r;
    mode_nxt      = (cfg_valid && cfg_ready) ? cfg_data : mode_r;
    out_valid_nxt = 1'b0;
    res_nxt       = res_r;
    free_fnd_nxt  = free_fnd_r;
    free_idx_nxt  = free_idx_r;
    hit_fnd_nxt   = hit_fnd_r;
    hit_idx_nxt   = hit_idx_r;
    best_fnd_nxt  = best_fnd_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    best_aud_nxt  = best_aud_r;
    best_hdl_nxt  = best_hdl_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    req_ok        = 1'b0;
    stole         = 1'b0;
    sel           = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt    = ST_SCAN;
          iss_nxt      = '0;
          free_fnd_nxt = 1'b0;
          hit_fnd_nxt  = 1'b0;
          best_fnd_nxt = 1'b0;
        end
      end

      ST_SCAN: begin
        if (!scan_done) begin
          iss_nxt    = iss_r + (SLOT_W+1)'(1);
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = iss_r[SLOT_W-1:0];
        end else begin
          state_nxt = ST_COMMIT;
        end
        if (ev_vld_r) begin
          if (!rd_busy && !free_fnd_r) begin
            free_fnd_nxt = 1'b1;
            free_idx_nxt = ev_idx_r;
          end
          if (rd_busy && !hit_fnd_r &&
              CMP_W'(rd_hdl) == CMP_W'(item_r.handle)) begin
            hit_fnd_nxt = 1'b1;
            hit_idx_nxt = ev_idx_r;
          end
          // strict compare keeps the lower index on ties
          if (rd_busy && rd_prio < item_r.priority_req &&
              (!best_fnd_r || better)) begin
            best_fnd_nxt  = 1'b1;
            best_idx_nxt  = ev_idx_r;
            best_prio_nxt = rd_prio;
            best_aud_nxt  = rd_aud;
            best_hdl_nxt  = rd_hdl;
          end
        end
      end

      ST_COMMIT: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        res_nxt       = '0;
        case (item_r.operation)
          vsa_pkg::OP_REQUEST: begin
            if (free_fnd_r) begin
              req_ok = 1'b1;
              sel    = free_idx_r;
            end else if (mode_r != vsa_pkg::MODE_NONE && best_fnd_r) begin
              req_ok = 1'b1;
              stole  = 1'b1;
              sel    = best_idx_r;
            end
            if (req_ok) begin
              ram_we        = 1'b1;
              ram_waddr     = sel;
              ram_wdata     = {nh_r, item_r.priority_req, vsa_pkg::FULL_AUDIBILITY};
              busy_nxt[sel] = 1'b1;
              if (!stole) begin
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              nh_nxt             = (nh_inc == '0) ? HANDLE_BITS'(1) : nh_inc;
              res_nxt.new_handle = 32'(nh_r);
              res_nxt.slot       = 5'(sel);
              res_nxt.stolen     = stole;
            end else begin
              res_nxt.status = vsa_pkg::STAT_NO_SLOT;
            end
          end
          vsa_pkg::OP_RELEASE, vsa_pkg::OP_UPDATE: begin
            if (item_r.handle == '0) begin
              res_nxt.status = vsa_pkg::STAT_INVALID;
            end else if (!hit_fnd_r) begin
              res_nxt.status = vsa_pkg::STAT_NOT_FOUND;
            end else begin
              res_nxt.slot = 5'(hit_idx_r);
              if (item_r.operation == vsa_pkg::OP_RELEASE) begin
                busy_nxt[hit_idx_r] = 1'b0;
                cnt_nxt             = cnt_r - CNT_W'(1);
              end else begin
                ram_we    = 1'b1;
                ram_waddr = hit_idx_r;
                ram_wdata = {HANDLE_BITS'(item_r.handle), item_r.priority_req,
                             item_r.audibility};
              end
            end
          end
          default: begin
            res_nxt.status = vsa_pkg::STAT_INVALID;
          end
        endcase
        res_nxt.active_count = 6'(cnt_nxt);
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      ev_vld_r    <= 1'b0;
      busy_r      <= '0;
      cnt_r       <= '0;
      nh_r        <= HANDLE_BITS'(1);
      mode_r      <= vsa_pkg::MODE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      ev_vld_r    <= ev_vld_nxt;
      busy_r      <= busy_nxt;
      cnt_r       <= cnt_nxt;
      nh_r        <= nh_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
    ev_idx_r    <= ev_idx_nxt;
    res_r       <= res_nxt;
    free_fnd_r  <= free_fnd_nxt;
    free_idx_r  <= free_idx_nxt;
    hit_fnd_r   <= hit_fnd_nxt;
    hit_idx_r   <= hit_idx_nxt;
    best_fnd_r  <= best_fnd_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    best_aud_r  <= best_aud_nxt;
    best_hdl_r  <= best_hdl_nxt;
  end

  // occupancy counter tracks the busy flags
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(busy_r)))
    else $error("occupied count out of step with busy flags");

  a_handle_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    nh_r != '0)
    else $error("next handle is zero");

  a_result_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_COMMIT)
    else $error("result strobe without commit");

  a_steal_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT && item_r.operation == vsa_pkg::OP_REQUEST && !free_fnd_r)
      |-> busy_r == '1)
    else $error("no free slot seen while some slot is free");

  a_stolen_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.stolen) |-> res_r.status == vsa_pkg::STAT_OK)
    else $error("steal reported with error status");

endmodule
